FILE: rtl/core/char_lcd_shadow_row_sync_core_defines.svh
// Assertion helpers for the display shadow core.
// All checks run on clk and are off while rst is high.
`ifndef CHAR_LCD_SHADOW_ROW_SYNC_CORE_DEFINES_SVH
`define CHAR_LCD_SHADOW_ROW_SYNC_CORE_DEFINES_SVH

// Same-cycle implication.
`define CLSRS_CHECK_NOW(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error(msg);

// Next-cycle implication.
`define CLSRS_CHECK_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: rtl/core/clsrs_pkg.sv
package clsrs_pkg;

  localparam int LINE_COLS = 20;
  localparam int LINE_BITS = LINE_COLS * 8;
  localparam int CUR_ROW_W = 2;
  localparam int CUR_COL_W = 5;
  localparam int ROWS_W    = 3;

  localparam int DEF_MAX_ROWS    = 4;
  localparam int DEF_MAX_COLS    = 20;
  localparam int DEF_QUEUE_DEPTH = 4;

  localparam int SMALL_ROWS = 2;
  localparam int SMALL_COLS = 16;
  localparam int BIG_ROWS   = 4;
  localparam int BIG_COLS   = 20;

  localparam logic [7:0] SPACE = 8'h20;
  localparam logic [7:0] TILDE = 8'h7E;

  // input function codes
  localparam logic [1:0] FN_STREAM = 2'd0;
  localparam logic [1:0] FN_BATCH  = 2'd1;
  localparam logic [1:0] FN_PUSH   = 2'd2;

  // display RAM address map (bit 7 stripped)
  localparam logic [6:0] ADDR_ROW1       = 7'h40;
  localparam logic [6:0] ADDR_S_ROW0_END = 7'h0F;
  localparam logic [6:0] ADDR_S_ROW1_END = 7'h4F;
  localparam logic [6:0] ADDR_L_ROW0_END = 7'h13;
  localparam logic [6:0] ADDR_L_ROW1_END = 7'h53;
  localparam logic [6:0] ADDR_L_ROW2     = 7'h14;
  localparam logic [6:0] ADDR_L_ROW2_END = 7'h27;
  localparam logic [6:0] ADDR_L_ROW3     = 7'h54;
  localparam logic [6:0] ADDR_L_ROW3_END = 7'h67;

  typedef enum logic [1:0] {
    CMD_CHAR,
    CMD_BATCH,
    CMD_PUSH
  } cmd_kind_t;

  typedef struct packed {
    logic                  compact;
    logic [ROWS_W-1:0]     rows;
    logic [CUR_COL_W-1:0]  cols;
  } lay_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [CUR_ROW_W-1:0]  row;
    logic [CUR_COL_W-1:0]  col;
    logic [7:0]            chr;
    logic [LINE_BITS-1:0]  text;
    logic                  forced;
  } cmd_t;

  typedef struct packed {
    logic [CUR_ROW_W-1:0]  row;
    logic [LINE_BITS-1:0]  text;
    logic                  stream;
    logic                  last;
  } line_t;

endpackage

FILE: rtl/core/clsrs_front.sv
// Front end: takes input transfers, tracks the cursor, turns items into
// queue commands. Address bytes and ignored items never reach the queue.
module clsrs_front (
  input  logic                    clk,
  input  logic                    rst,
  input  clsrs_pkg::lay_t         lay,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [175:0]            s_tdata,
  input  logic [1:0]              s_tuser,
  input  logic                    q_full,
  output logic                    q_push,
  output clsrs_pkg::cmd_t         q_cmd
);

  logic                              accept;
  logic [7:0]                        data_byte;
  logic [6:0]                        addr;
  logic [clsrs_pkg::CUR_ROW_W-1:0]   cursor_row;
  logic [clsrs_pkg::CUR_COL_W-1:0]   cursor_col;
  logic [clsrs_pkg::CUR_ROW_W-1:0]   dec_row;
  logic [clsrs_pkg::CUR_COL_W-1:0]   dec_col;
  logic [clsrs_pkg::CUR_COL_W-1:0]   col_inc;
  logic [clsrs_pkg::ROWS_W-1:0]      row_inc;
  logic                              char_ok;
  logic                              row_ok;
  logic [clsrs_pkg::LINE_BITS-1:0]   raw_text;
  logic [clsrs_pkg::LINE_BITS-1:0]   clean_text;
  logic [4:0]                        text_len;

  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign data_byte = s_tdata[7:0];
  assign addr      = s_tdata[6:0];
  assign raw_text  = s_tdata[169:10];
  assign text_len  = s_tdata[174:170];

  assign char_ok = ({1'b0, cursor_row} < lay.rows) && (cursor_col < lay.cols);
  assign row_ok  = ({1'b0, s_tdata[9:8]} < lay.rows);
  assign col_inc = cursor_col + 5'd1;
  assign row_inc = {1'b0, cursor_row} + 3'd1;

  // address decode; anything off the map lands at home
  always_comb begin
    dec_row = '0;
    dec_col = '0;
    if (lay.compact) begin
      if (addr <= clsrs_pkg::ADDR_S_ROW0_END) begin
        dec_col = addr[4:0];
      end else if (addr >= clsrs_pkg::ADDR_ROW1 && addr <= clsrs_pkg::ADDR_S_ROW1_END) begin
        dec_row = 2'd1;
        dec_col = 5'(addr - clsrs_pkg::ADDR_ROW1);
      end
    end else begin
      if (addr <= clsrs_pkg::ADDR_L_ROW0_END) begin
        dec_col = addr[4:0];
      end else if (addr >= clsrs_pkg::ADDR_ROW1 && addr <= clsrs_pkg::ADDR_L_ROW1_END) begin
        dec_row = 2'd1;
        dec_col = 5'(addr - clsrs_pkg::ADDR_ROW1);
      end else if (addr >= clsrs_pkg::ADDR_L_ROW2 && addr <= clsrs_pkg::ADDR_L_ROW2_END) begin
        dec_row = 2'd2;
        dec_col = 5'(addr - clsrs_pkg::ADDR_L_ROW2);
      end else if (addr >= clsrs_pkg::ADDR_L_ROW3 && addr <= clsrs_pkg::ADDR_L_ROW3_END) begin
        dec_row = 2'd3;
        dec_col = 5'(addr - clsrs_pkg::ADDR_L_ROW3);
      end
    end
  end

  // push text: non-printables and columns past length or width become spaces
  always_comb begin
    logic [7:0] ch;
    for (int i = 0; i < clsrs_pkg::LINE_COLS; i++) begin
      ch = raw_text[8*i +: 8];
      if ((5'(i) < text_len) && (5'(i) < lay.cols) &&
          (ch >= clsrs_pkg::SPACE) && (ch <= clsrs_pkg::TILDE)) begin
        clean_text[8*i +: 8] = ch;
      end else begin
        clean_text[8*i +: 8] = clsrs_pkg::SPACE;
      end
    end
  end

  always_comb begin
    q_cmd        = '0;
    q_cmd.kind   = clsrs_pkg::CMD_CHAR;
    q_cmd.row    = cursor_row;
    q_cmd.col    = cursor_col;
    q_cmd.chr    = data_byte;
    q_cmd.text   = clean_text;
    q_cmd.forced = s_tdata[175];
    q_push       = 1'b0;
    unique case (s_tuser)
      clsrs_pkg::FN_STREAM: begin
        q_push = accept && !data_byte[7] && char_ok;
      end
      clsrs_pkg::FN_BATCH: begin
        q_cmd.kind = clsrs_pkg::CMD_BATCH;
        q_push     = accept;
      end
      clsrs_pkg::FN_PUSH: begin
        q_cmd.kind = clsrs_pkg::CMD_PUSH;
        q_cmd.row  = s_tdata[9:8];
        q_push     = accept && row_ok;
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_row <= '0;
      cursor_col <= '0;
    end else if (accept && s_tuser == clsrs_pkg::FN_STREAM) begin
      if (data_byte[7]) begin
        cursor_row <= dec_row;
        cursor_col <= dec_col;
      end else if (char_ok) begin
        if (col_inc >= lay.cols) begin
          cursor_col <= '0;
          cursor_row <= (row_inc == lay.rows) ? '0 : row_inc[clsrs_pkg::CUR_ROW_W-1:0];
        end else begin
          cursor_col <= col_inc;
        end
      end
    end
  end

endmodule

FILE: rtl/core/clsrs_queue.sv
// Command queue between front and back end.
module clsrs_queue #(
  parameter int DEPTH = clsrs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  clsrs_pkg::cmd_t   wr_cmd,
  input  logic              pop,
  output clsrs_pkg::cmd_t   head,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  clsrs_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if ((push && !full) && !(pop && !empty)) begin
        count <= count + 1'b1;
      end else if (!(push && !full) && (pop && !empty)) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/clsrs_back.sv
// Back end: owns screen and sent copies, dirty flags and the output register.
module clsrs_back #(
  parameter int MAX_ROWS = clsrs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = clsrs_pkg::DEF_MAX_COLS
) (
  input  logic              clk,
  input  logic              rst,
  input  clsrs_pkg::lay_t   lay,
  input  clsrs_pkg::cmd_t   head,
  input  logic              q_empty,
  output logic              q_pop,
  output clsrs_pkg::line_t  res,
  output logic              out_valid,
  input  logic              out_ready
);

  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ROW_BITS = MAX_COLS * 8;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  state_t                          state;
  logic [ROW_BITS-1:0]             screen [MAX_ROWS];
  logic [ROW_BITS-1:0]             sent   [MAX_ROWS];
  logic [MAX_ROWS-1:0]             dirty;
  logic [MAX_ROWS-1:0]             emit_mask;
  logic [ROW_W-1:0]                scan_row;
  logic [ROW_W-1:0]                emit_row;
  logic [ROW_W-1:0]                rd_row;
  logic [ROW_W-1:0]                sent_row;
  logic [ROW_W-1:0]                cmd_row;
  logic [ROW_BITS-1:0]             screen_rd;
  logic [ROW_BITS-1:0]             sent_rd;
  logic [ROW_BITS-1:0]             cmp_a;
  logic [ROW_BITS-1:0]             merged;
  logic [MAX_COLS-1:0]             keep;
  logic                            diff;
  logic                            push_send;
  logic                            out_free;
  logic                            out_load;
  logic                            emit_last;
  logic [clsrs_pkg::LINE_BITS-1:0] emit_line;

  assign cmd_row   = head.row[ROW_W-1:0];
  assign rd_row    = (state == S_EMIT) ? emit_row : scan_row;
  assign sent_row  = (state == S_IDLE) ? cmd_row : scan_row;
  assign screen_rd = screen[rd_row];
  assign sent_rd   = sent[sent_row];
  assign cmp_a     = (state == S_IDLE) ? head.text[ROW_BITS-1:0] : screen_rd;
  assign out_free  = !out_valid || out_ready;
  assign push_send = head.forced || diff;
  assign emit_last = ((emit_mask & (emit_mask - 1'b1)) == '0);

  // output register gets a new row this cycle
  assign out_load  = (state == S_IDLE && q_pop && head.kind == clsrs_pkg::CMD_PUSH &&
                      push_send) ||
                     (state == S_EMIT && emit_mask != '0 && out_free);

  // one row comparator shared by push and batch scan
  always_comb begin
    diff = 1'b0;
    for (int i = 0; i < MAX_COLS; i++) begin
      keep[i] = (5'(i) < lay.cols);
      merged[8*i +: 8] = keep[i] ? cmp_a[8*i +: 8] : sent_rd[8*i +: 8];
      if (keep[i] && (cmp_a[8*i +: 8] != sent_rd[8*i +: 8])) begin
        diff = 1'b1;
      end
    end
  end

  always_comb begin
    emit_row = '0;
    for (int r = MAX_ROWS - 1; r >= 0; r--) begin
      if (emit_mask[r]) begin
        emit_row = ROW_W'(r);
      end
    end
  end

  for (genvar i = 0; i < clsrs_pkg::LINE_COLS; i++) begin : g_line
    if (i < MAX_COLS) begin : g_col
      assign emit_line[8*i +: 8] = keep[i] ? screen_rd[8*i +: 8] : clsrs_pkg::SPACE;
    end else begin : g_pad
      assign emit_line[8*i +: 8] = clsrs_pkg::SPACE;
    end
  end

  always_comb begin
    q_pop = 1'b0;
    if (state == S_IDLE && !q_empty) begin
      q_pop = (head.kind != clsrs_pkg::CMD_PUSH) || !push_send || out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dirty     <= '0;
      emit_mask <= '0;
      scan_row  <= '0;
      out_valid <= 1'b0;
      for (int r = 0; r < MAX_ROWS; r++) begin
        screen[r] <= {MAX_COLS{clsrs_pkg::SPACE}};
        sent[r]   <= '0;
      end
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            unique case (head.kind)
              clsrs_pkg::CMD_CHAR: begin
                for (int r = 0; r < MAX_ROWS; r++) begin
                  for (int i = 0; i < MAX_COLS; i++) begin
                    if (ROW_W'(r) == cmd_row && 5'(i) == head.col) begin
                      screen[r][8*i +: 8] <= head.chr;
                    end
                  end
                end
                dirty[cmd_row] <= 1'b1;
              end
              clsrs_pkg::CMD_PUSH: begin
                for (int i = 0; i < MAX_COLS; i++) begin
                  if (keep[i]) begin
                    screen[cmd_row][8*i +: 8] <= head.text[8*i +: 8];
                  end
                end
                if (push_send) begin
                  sent[cmd_row] <= merged;
                  res.row       <= head.row;
                  res.text      <= head.text;
                  res.stream    <= 1'b0;
                  res.last      <= 1'b1;
                  out_valid     <= 1'b1;
                end
              end
              clsrs_pkg::CMD_BATCH: begin
                scan_row  <= '0;
                emit_mask <= '0;
                state     <= S_SCAN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (dirty[scan_row]) begin
            dirty[scan_row] <= 1'b0;
            if (diff) begin
              sent[scan_row]      <= merged;
              emit_mask[scan_row] <= 1'b1;
            end
          end
          if (3'(scan_row) == lay.rows - 3'd1) begin
            state <= S_EMIT;
          end else begin
            scan_row <= scan_row + 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_mask == '0) begin
            state <= S_IDLE;
          end else if (out_free) begin
            res.row             <= 2'(emit_row);
            res.text            <= emit_line;
            res.stream          <= 1'b1;
            res.last            <= emit_last;
            out_valid           <= 1'b1;
            emit_mask[emit_row] <= 1'b0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/char_lcd_shadow_row_sync_core.sv
// Character display shadow with row sync. Stream bytes (tuser function 0)
// either set the cursor (bit 7 set: a display RAM address, mapped for a
// 2x16 or 4x20 layout, off-map addresses go home) or are stored raw at the
// cursor, which then advances and wraps. A batch end (function 1) sends every
// dirty row that differs from the copy last sent; a software push
// (function 2) replaces one row with sanitized text and sends it if it
// changed or if forced. Function 3 is dropped. Each sent row is one output
// transfer of 20 columns, spaces past the row width; tuser is 1 for rows sent
// at a batch end and tlast marks the last row caused by one input.
// Timing: a front end decodes items at one per cycle, while the command
// queue of QUEUE_DEPTH entries has room; a back end executes them. It
// executes a stream byte or a push in its idle state, so bytes sustain one
// per clock while it is idle. A batch end runs a scan state, comparing one
// row per cycle against the sent copy, then an emit state, sending one row
// per cycle, then returns to idle. A full output register that is not taken
// stalls the back end; the queue keeps the input side going.
// Row storage is reset in flip-flops directly: no clearing pass after reset.
// small_layout (cfg_we/cfg_wdata) may only change while the block is idle.
`include "char_lcd_shadow_row_sync_core_defines.svh"

module char_lcd_shadow_row_sync_core #(
  parameter int MAX_ROWS    = clsrs_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS    = clsrs_pkg::DEF_MAX_COLS,
  parameter int QUEUE_DEPTH = clsrs_pkg::DEF_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,    // small_layout
  input  logic          s_tvalid,
  output logic          s_tready,
  // data_byte[7:0], target_row[9:8], text_lo[73:10], text_mid[137:74],
  // text_hi[169:138], text_len[174:170], force_send[175]
  input  logic [175:0]  s_tdata,
  input  logic [1:0]    s_tuser,      // func
  output logic          m_tvalid,
  input  logic          m_tready,
  // line_row[1:0], line_lo[65:2], line_mid[129:66], line_hi[161:130],
  // zero fill [167:162]
  output logic [167:0]  m_tdata,
  output logic          m_tuser,      // from_stream
  output logic          m_tlast       // last_of_run
);

  // layout limits clipped to the built size
  localparam int LAY_SMALL_ROWS = (clsrs_pkg::SMALL_ROWS > MAX_ROWS) ? MAX_ROWS
                                                                     : clsrs_pkg::SMALL_ROWS;
  localparam int LAY_BIG_ROWS   = (clsrs_pkg::BIG_ROWS > MAX_ROWS) ? MAX_ROWS
                                                                   : clsrs_pkg::BIG_ROWS;
  localparam int LAY_SMALL_COLS = (clsrs_pkg::SMALL_COLS > MAX_COLS) ? MAX_COLS
                                                                     : clsrs_pkg::SMALL_COLS;
  localparam int LAY_BIG_COLS   = (clsrs_pkg::BIG_COLS > MAX_COLS) ? MAX_COLS
                                                                   : clsrs_pkg::BIG_COLS;

  logic               small_layout;
  clsrs_pkg::lay_t    lay;
  clsrs_pkg::cmd_t    q_in;
  clsrs_pkg::cmd_t    q_head;
  clsrs_pkg::line_t   res;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_layout <= 1'b0;
    end else if (cfg_we) begin
      small_layout <= cfg_wdata;
    end
  end

  assign lay.compact = small_layout;
  assign lay.rows    = small_layout ? clsrs_pkg::ROWS_W'(LAY_SMALL_ROWS)
                                    : clsrs_pkg::ROWS_W'(LAY_BIG_ROWS);
  assign lay.cols    = small_layout ? clsrs_pkg::CUR_COL_W'(LAY_SMALL_COLS)
                                    : clsrs_pkg::CUR_COL_W'(LAY_BIG_COLS);

  clsrs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .lay      (lay),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (q_in)
  );

  clsrs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_cmd (q_in),
    .pop    (q_pop),
    .head   (q_head),
    .full   (q_full),
    .empty  (q_empty)
  );

  clsrs_back #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .lay       (lay),
    .head      (q_head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .res       (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

  assign m_tdata = {6'b0, res.text, res.row};
  assign m_tuser = res.stream;
  assign m_tlast = res.last;

  // a push sends at most one row, so it always closes its run
  `CLSRS_CHECK_NOW(a_push_single, m_tvalid && !m_tuser, m_tlast, "push result not last")
  // only rows inside the current layout are ever sent
  `CLSRS_CHECK_NOW(a_row_in_layout, m_tvalid, 3'(m_tdata[1:0]) < lay.rows, "row outside layout")
  // the front end never writes a full queue
  `CLSRS_CHECK_NOW(a_no_overflow, q_push, !q_full, "command queue overflow")
  // a queued command is visible to the back end the next cycle
  `CLSRS_CHECK_NEXT(a_push_lands, q_push, !q_empty, "queued command lost")

endmodule
